// ===== design/tpim_pkg.sv =====
`default_nettype none

package tpim_pkg;

	localparam int DATA_W = 32;

	// Divisor of the clamped peak height that gives the medium height.
	localparam int MED_HEIGHT_DIV = 4;
	// Divisor of the window width that gives the centre rectangle width.
	localparam int MAX_HEIGHT_RANGE_DIV = 2;

	// The clamp divides 2^32, which needs one more dividend bit than a word.
	localparam int CLAMP_DIV_BITS = DATA_W + 1;
	localparam int LOOKUP_DIV_BITS = DATA_W;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef struct packed {
		logic                opcode;
		logic [DATA_W-1:0]   symbol_value;
		logic [DATA_W-1:0]   decoded_count;
		logic [DATA_W-1:0]   window_left;
		logic [DATA_W-1:0]   window_right;
		logic [DATA_W-1:0]   peak_height;
		logic [DATA_W-1:0]   value_range;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0]   interval_total;
		logic [DATA_W-1:0]   interval_low;
		logic [DATA_W-1:0]   symbol_frequency;
		logic [DATA_W-1:0]   decoded_value;
		logic                in_window;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/tpim_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per pipeline stage. A side vector travels
// with each request so the caller keeps its context aligned with the quotient.
module tpim_div #(
	parameter int NW = 32,
	parameter int SW = 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_vld,
	input  wire logic [NW-1:0]                 num,
	input  wire logic [tpim_pkg::DATA_W-1:0]   den,
	input  wire logic [SW-1:0]                 side,
	output logic                               out_vld,
	output logic [NW-1:0]                      quot,
	output logic [tpim_pkg::DATA_W-1:0]        rem,
	output logic [SW-1:0]                      side_out
);

	localparam int W = tpim_pkg::DATA_W;

	logic          vld_s  [NW];
	logic [W-1:0]  rem_s  [NW];
	logic [NW-1:0] num_s  [NW];
	logic [NW-1:0] quo_s  [NW];
	logic [W-1:0]  den_s  [NW];
	logic [SW-1:0] side_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          v_in;
		logic [W-1:0]  r_in;
		logic [NW-1:0] n_in;
		logic [NW-1:0] q_in;
		logic [W-1:0]  d_in;
		logic [SW-1:0] s_in;
		logic [W:0]    shifted;
		logic [W+1:0]  trial;
		logic          take;
		logic [NW-1:0] q_next;

		if (k == 0) begin : g_first
			assign v_in = in_vld;
			assign r_in = '0;
			assign n_in = num;
			assign q_in = '0;
			assign d_in = den;
			assign s_in = side;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign r_in = rem_s[k-1];
			assign n_in = num_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
			assign s_in = side_s[k-1];
		end

		assign shifted = {r_in, n_in[NW-1-k]};
		assign trial = {1'b0, shifted} - {2'b00, d_in};
		assign take = !trial[W+1];

		always_comb begin
			q_next = q_in;
			q_next[NW-1-k] = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? trial[W-1:0] : shifted[W-1:0];
				num_s[k]  <= n_in;
				quo_s[k]  <= q_next;
				den_s[k]  <= d_in;
				side_s[k] <= s_in;
			end
		end
	end

	assign out_vld  = vld_s[NW-1];
	assign quot     = quo_s[NW-1];
	assign rem      = rem_s[NW-1];
	assign side_out = side_s[NW-1];

endmodule

`default_nettype wire

// ===== design/three_step_pulse_interval_model_unit.sv =====
`default_nettype none

// Frequency model for an arithmetic coder with a three-step pulse inside a
// predicted window. Each request on req carries an opcode: encode turns a
// value into (total, low, frequency), decode turns a decoder count back into
// the value, the cell-aligned low and the frequency.
// Both channels use valid and stall; a request moves at a clock edge where
// valid is high and stall is low. Every request yields exactly one response.
// The path holds 72 register stages. Throughput is one request per cycle
// while no response is held by rsp_stall. The depth comes from two
// bit-per-stage dividers: 33 stages for the height clamp (2^32 / span)
// and 32 stages for the decode cell lookup.
// The whole pipeline advances together. When rsp is held by rsp_stall, the
// pipeline freezes and req_stall rises in the same cycle; nothing is lost or
// repeated. Reset (arst_n low) clears every valid bit at once, and the block
// takes a request in the first cycle after reset is released.
module three_step_pulse_interval_model_unit #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire tpim_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output tpim_pkg::rsp_t       rsp
);

	localparam int W = tpim_pkg::DATA_W;
	localparam logic [W-1:0] VMASK = W'((64'd1 << VALUE_BITS) - 64'd1);
	localparam int MH_SHIFT = $clog2(tpim_pkg::MED_HEIGHT_DIV);
	localparam int BIG_SHIFT = $clog2(tpim_pkg::MAX_HEIGHT_RANGE_DIV);

	typedef enum logic [2:0] {
		REG_BELOW,
		REG_LOW_MED,
		REG_PEAK,
		REG_HIGH_MED,
		REG_ABOVE
	} region_t;

	typedef struct packed {
		logic          op;
		logic [W-1:0]  v;
		logic [W-1:0]  cnt;
		logic [W-1:0]  lo;
		logic [W-1:0]  hi;
		logic [W-1:0]  h;
		logic [W-1:0]  rng;
	} base_t;

	typedef struct packed {
		base_t         b;
		logic          clamp;
	} clamp_side_t;

	typedef struct packed {
		logic          op;
		logic [W-1:0]  tot;
		logic [W-1:0]  low;
		logic [W-1:0]  sym;
		logic [W-1:0]  val;
		logic          hit;
		logic          need_div;
		logic          div_zero;
		logic [W-1:0]  val_base;
	} look_side_t;

	// One enable moves every stage. It holds only while a response waits.
	logic adv;
	assign adv = !(rsp_valid && rsp_stall);
	assign req_stall = !adv;

	// Stage 1: mask the value-width fields and take the window span.
	logic          vld_s1;
	base_t         b_s1;
	logic [W-1:0]  d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s1.op  <= req.opcode;
			b_s1.v   <= req.symbol_value & VMASK;
			b_s1.cnt <= req.decoded_count;
			b_s1.lo  <= req.window_left & VMASK;
			b_s1.hi  <= req.window_right & VMASK;
			b_s1.h   <= req.peak_height;
			b_s1.rng <= req.value_range & VMASK;
			d_s1     <= (req.window_right & VMASK) - (req.window_left & VMASK);
		end
	end

	// Stage 2: height times span decides whether the height gets clamped.
	logic          vld_s2;
	clamp_side_t   cs_s2;
	logic [W-1:0]  d_s2;
	logic [2*W-1:0] prod;

	assign prod = {{W{1'b0}}, b_s1.h} * {{W{1'b0}}, d_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_s2.b     <= b_s1;
			cs_s2.clamp <= prod[2*W-1:W] != '0;
			d_s2        <= d_s1;
		end
	end

	// Clamp divider: 2^32 / span, computed for every request.
	logic                        vld_c;
	logic [tpim_pkg::CLAMP_DIV_BITS-1:0] quo_c;
	logic [W-1:0]                rem_c;
	logic [$bits(clamp_side_t)-1:0] side_c;
	clamp_side_t                 cs_c;

	tpim_div #(
		.NW (tpim_pkg::CLAMP_DIV_BITS),
		.SW ($bits(clamp_side_t))
	) u_clamp_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s2),
		.num      ({1'b1, {W{1'b0}}}),
		.den      (d_s2),
		.side     (cs_s2),
		.out_vld  (vld_c),
		.quot     (quo_c),
		.rem      (rem_c),
		.side_out (side_c)
	);

	assign cs_c = clamp_side_t'(side_c);

	// Stage 3: rectangle widths and the medium height.
	logic          vld_s3;
	base_t         b_s3;
	logic [W-1:0]  med_s3;
	logic [W-1:0]  big_s3;
	logic [W-1:0]  mh_s3;

	base_t         b_c;
	logic [W-1:0]  hc;
	logic [W-1:0]  w_c;
	logic [W-1:0]  big0;
	logic [W-1:0]  med_c;
	logic [W-1:0]  mh_c;

	always_comb begin
		// The clamp remainder is not used anywhere; only the quotient is needed.
		hc    = cs_c.clamp ? quo_c[W-1:0] : cs_c.b.h;
		b_c   = cs_c.b;
		b_c.h = hc;
		w_c   = cs_c.b.hi - cs_c.b.lo + W'(1);
		big0  = w_c >> BIG_SHIFT;
		med_c = (w_c - big0) >> 1;
		mh_c  = hc >> MH_SHIFT;
		if (mh_c == '0) begin
			mh_c = W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s3     <= b_c;
			med_s3   <= med_c;
			big_s3   <= w_c - med_c - med_c;
			mh_s3    <= mh_c;
		end
	end

	// Stage 4: rectangle areas, and where an encoded value falls.
	logic          vld_s4;
	base_t         b_s4;
	logic [W-1:0]  med_s4;
	logic [W-1:0]  big_s4;
	logic [W-1:0]  mh_s4;
	logic [W-1:0]  medsum_s4;
	logic [W-1:0]  bigsum_s4;
	region_t       ereg_s4;
	logic [W-1:0]  fac_s4;
	logic [W-1:0]  mul_s4;

	region_t       ereg_c;
	logic [W-1:0]  fac_c;
	logic [W-1:0]  mul_c;

	always_comb begin
		fac_c = b_s3.v;
		mul_c = mh_s3;
		if (b_s3.v >= b_s3.lo && b_s3.v <= b_s3.hi) begin
			if (b_s3.v < b_s3.lo + med_s3) begin
				ereg_c = REG_LOW_MED;
				fac_c  = b_s3.v - b_s3.lo;
			end else if (b_s3.v > b_s3.hi - med_s3) begin
				ereg_c = REG_HIGH_MED;
				fac_c  = b_s3.v - (b_s3.hi - med_s3) - W'(1);
			end else begin
				ereg_c = REG_PEAK;
				fac_c  = b_s3.v - b_s3.lo - med_s3;
				mul_c  = b_s3.h;
			end
		end else if (b_s3.v > b_s3.hi) begin
			// Above the window every value has frequency one.
			ereg_c = REG_ABOVE;
			fac_c  = b_s3.v - b_s3.hi - W'(1);
			mul_c  = W'(1);
		end else begin
			ereg_c = REG_BELOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s4      <= b_s3;
			med_s4    <= med_s3;
			big_s4    <= big_s3;
			mh_s4     <= mh_s3;
			medsum_s4 <= med_s3 * mh_s3;
			bigsum_s4 <= big_s3 * b_s3.h;
			ereg_s4   <= ereg_c;
			fac_s4    <= fac_c;
			mul_s4    <= mul_c;
		end
	end

	// Stage 5: region thresholds, the total and the in-cell encode offset.
	logic          vld_s5;
	base_t         b_s5;
	logic [W-1:0]  med_s5;
	logic [W-1:0]  big_s5;
	logic [W-1:0]  mh_s5;
	logic [W-1:0]  t1_s5;
	logic [W-1:0]  t2_s5;
	logic [W-1:0]  t3_s5;
	logic [W-1:0]  tot_s5;
	logic [W-1:0]  ep_s5;
	region_t       ereg_s5;

	logic [W-1:0]  t1_c;
	logic [W-1:0]  t2_c;
	logic [W-1:0]  t3_c;

	assign t1_c = b_s4.lo + medsum_s4;
	assign t2_c = t1_c + bigsum_s4;
	assign t3_c = t2_c + medsum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s5    <= b_s4;
			med_s5  <= med_s4;
			big_s5  <= big_s4;
			mh_s5   <= mh_s4;
			t1_s5   <= t1_c;
			t2_s5   <= t2_c;
			t3_s5   <= t3_c;
			tot_s5  <= t3_c + (b_s4.rng - b_s4.hi - W'(1));
			ep_s5   <= fac_s4 * mul_s4;
			ereg_s5 <= ereg_s4;
		end
	end

	// Stage 6: finish encode, pick the decode region and its divisor.
	logic          vld_s6;
	look_side_t    ls_s6;
	logic [W-1:0]  off_s6;
	logic [W-1:0]  dvs_s6;

	look_side_t    ls_c;
	region_t       dreg_c;
	logic [W-1:0]  off_c;
	logic [W-1:0]  dvs_c;

	always_comb begin
		ls_c.op       = b_s5.op;
		ls_c.tot      = tot_s5;
		ls_c.need_div = 1'b0;
		ls_c.val_base = b_s5.lo;
		off_c         = b_s5.cnt - b_s5.lo;
		dvs_c         = b_s5.h;

		if (b_s5.cnt < b_s5.lo) begin
			dreg_c = REG_BELOW;
		end else if (b_s5.cnt < t1_s5) begin
			dreg_c = REG_LOW_MED;
		end else if (b_s5.cnt < t2_s5) begin
			dreg_c = REG_PEAK;
		end else if (b_s5.cnt < t3_s5) begin
			dreg_c = REG_HIGH_MED;
		end else begin
			dreg_c = REG_ABOVE;
		end

		if (b_s5.op == tpim_pkg::OP_ENCODE) begin
			ls_c.val = b_s5.v;
			ls_c.hit = 1'b0;
			ls_c.sym = W'(1);
			case (ereg_s5)
				REG_LOW_MED: begin
					ls_c.low = b_s5.lo + ep_s5;
					ls_c.sym = mh_s5;
					ls_c.hit = 1'b1;
				end
				REG_PEAK: begin
					ls_c.low = t1_s5 + ep_s5;
					ls_c.sym = b_s5.h;
					ls_c.hit = 1'b1;
				end
				REG_HIGH_MED: begin
					ls_c.low = t2_s5 + ep_s5;
					ls_c.sym = mh_s5;
					ls_c.hit = 1'b1;
				end
				REG_ABOVE: begin
					ls_c.low = t3_s5 + ep_s5;
				end
				default: begin
					ls_c.low = b_s5.v;
				end
			endcase
		end else begin
			ls_c.low = b_s5.cnt;
			ls_c.val = b_s5.cnt;
			ls_c.sym = W'(1);
			ls_c.hit = 1'b0;
			case (dreg_c)
				REG_LOW_MED: begin
					ls_c.sym      = mh_s5;
					ls_c.hit      = 1'b1;
					ls_c.need_div = 1'b1;
					dvs_c         = mh_s5;
				end
				REG_PEAK: begin
					ls_c.sym      = b_s5.h;
					ls_c.hit      = 1'b1;
					ls_c.need_div = 1'b1;
					ls_c.val_base = b_s5.lo + med_s5;
					off_c         = b_s5.cnt - t1_s5;
				end
				REG_HIGH_MED: begin
					ls_c.sym      = mh_s5;
					ls_c.hit      = 1'b1;
					ls_c.need_div = 1'b1;
					ls_c.val_base = b_s5.lo + med_s5 + big_s5;
					off_c         = b_s5.cnt - t2_s5;
					dvs_c         = mh_s5;
				end
				REG_ABOVE: begin
					ls_c.val = b_s5.hi + W'(1) + b_s5.cnt - t3_s5;
				end
				default: begin
					ls_c.val = b_s5.cnt;
				end
			endcase
		end
		ls_c.div_zero = dvs_c == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ls_s6  <= ls_c;
			off_s6 <= off_c;
			dvs_s6 <= dvs_c;
		end
	end

	// Lookup divider: the cell index and the offset inside the cell.
	logic                        vld_l;
	logic [W-1:0]                quo_l;
	logic [W-1:0]                rem_l;
	logic [$bits(look_side_t)-1:0] side_l;
	look_side_t                  ls_l;

	tpim_div #(
		.NW (tpim_pkg::LOOKUP_DIV_BITS),
		.SW ($bits(look_side_t))
	) u_lookup_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s6),
		.num      (off_s6),
		.den      (dvs_s6),
		.side     (ls_s6),
		.out_vld  (vld_l),
		.quot     (quo_l),
		.rem      (rem_l),
		.side_out (side_l)
	);

	assign ls_l = look_side_t'(side_l);

	// Output register.
	tpim_pkg::rsp_t rsp_c;

	always_comb begin
		rsp_c.interval_total   = ls_l.tot;
		rsp_c.symbol_frequency = ls_l.sym;
		rsp_c.in_window        = ls_l.hit;
		rsp_c.interval_low     = ls_l.low;
		rsp_c.decoded_value    = ls_l.val & VMASK;
		if (ls_l.need_div) begin
			// A zero divisor leaves the count where it is and the value at the cell base.
			if (ls_l.div_zero) begin
				rsp_c.decoded_value = ls_l.val_base & VMASK;
			end else begin
				rsp_c.interval_low  = ls_l.low - rem_l;
				rsp_c.decoded_value = (ls_l.val_base + quo_l) & VMASK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= vld_l;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp <= rsp_c;
		end
	end

`ifndef SYNTH
	// The input side stalls only while a response is held at the output.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("req_stall without a held response");

	// Values outside the window always carry frequency one.
	a_outside_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.in_window) |-> (rsp.symbol_frequency == W'(1)))
		else $error("out-of-window response with frequency other than one");

	// A frozen pipeline keeps its clamp divider output in place.
	a_freeze_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && vld_c) |=> (vld_c && $stable(quo_c)))
		else $error("clamp divider moved while frozen");
`endif

endmodule

`default_nettype wire
